@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the stable priority queue.
// Standalone header; the assertions compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SPQ_ASSERT_CLK(lbl, clk_sig, rst_n_sig, prop) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (prop)) \
		else $error("assertion failed");
`define SPQ_ASSERT(lbl, prop) `SPQ_ASSERT_CLK(lbl, clk, arst_n, prop)
`else
`define SPQ_ASSERT_CLK(lbl, clk_sig, rst_n_sig, prop)
`define SPQ_ASSERT(lbl, prop)
`endif
`endif

@@ rtl/spq_pkg.sv @@
// Types, constants and pointer helpers of the stable priority queue.
// No dependencies; used by the engine and the top level.
`default_nettype none
package spq_pkg;
	localparam int DEPTH = 16;
	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [IW:0] DEPTH_W = (IW + 1)'(DEPTH);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_POP    = 1'b1;

	typedef struct packed {
		logic [3:0]  prio;
		logic [31:0] tag;
		logic [7:0]  age;
	} entry_t;

	localparam int EW = $bits(entry_t);

	typedef struct packed {
		logic        opcode;
		logic [3:0]  prio;
		logic [31:0] tag;
		logic [7:0]  age;
	} item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  prio;
		logic [31:0] tag;
		logic [7:0]  age;
		logic        now_empty;
	} result_t;

	typedef struct packed {
		logic          idle;
		logic          res_valid;
		logic [CW-1:0] count;
	} eng_stat_t;

	function automatic logic [IW-1:0] ptr_add(input logic [IW-1:0] a, input logic [IW-1:0] b);
		logic [IW:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		if (sum >= DEPTH_W) begin
			sum = sum - DEPTH_W;
		end
		return sum[IW-1:0];
	endfunction

	function automatic logic [IW-1:0] ptr_inc(input logic [IW-1:0] a);
		return ptr_add(a, IW'(1));
	endfunction

	function automatic logic [IW-1:0] ptr_dec(input logic [IW-1:0] a);
		return ptr_add(a, IW'(DEPTH - 1));
	endfunction
endpackage
`default_nettype wire

@@ rtl/spq_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`default_nettype none
module spq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                       clk,
	input  wire logic                       wr_en,
	input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
	input  wire logic [WIDTH-1:0]           wr_data,
	input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
	output logic      [WIDTH-1:0]           rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end
endmodule
`default_nettype wire

@@ rtl/spq_engine.sv @@
// Sequencer of the queue: keeps head and fill count and walks the entry RAM
// one slot per cycle to shift entries on insert. Depends on spq_pkg, spq_ram.
`default_nettype none
module spq_engine (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire spq_pkg::item_t     item,
	input  wire logic               res_ready,
	output spq_pkg::result_t        res,
	output spq_pkg::eng_stat_t      stat
);
	import spq_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SCAN  = 3'd1;
	localparam logic [2:0] S_PLACE = 3'd2;
	localparam logic [2:0] S_POP   = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [2:0]    state_q, state_d;
	logic [IW-1:0] head_q, head_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [IW-1:0] idx_q, idx_d;
	item_t         item_q;
	result_t       res_q, res_d;
	logic          load_item;

	logic          wr_en;
	logic [IW-1:0] wr_addr;
	entry_t        wr_data;
	logic [IW-1:0] rd_addr;
	entry_t        rd_data;
	logic [IW-1:0] pos, pos_nx, pos_pv;
	entry_t        in_entry, held_entry;

	spq_ram #(
		.WIDTH(EW),
		.DEPTH(DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_comb begin
		pos        = ptr_add(head_q, idx_q);
		pos_nx     = ptr_inc(pos);
		pos_pv     = ptr_dec(pos);
		in_entry   = '{prio: item.prio, tag: item.tag, age: item.age};
		held_entry = '{prio: item_q.prio, tag: item_q.tag, age: item_q.age};

		state_d   = state_q;
		head_d    = head_q;
		cnt_d     = cnt_q;
		idx_d     = idx_q;
		res_d     = res_q;
		load_item = 1'b0;
		wr_en     = 1'b0;
		wr_addr   = pos_nx;
		wr_data   = rd_data;
		rd_addr   = head_q;

		case (state_q)
			S_IDLE: begin
				if (start) begin
					load_item = 1'b1;
					res_d     = '0;
					state_d   = S_DONE;
					if (item.opcode == OP_INSERT) begin
						if (cnt_q == DEPTH_C) begin
							res_d.status = ST_FULL;
						end else if (cnt_q == '0) begin
							wr_en   = 1'b1;
							wr_addr = head_q;
							wr_data = in_entry;
							cnt_d   = CW'(1);
						end else begin
							idx_d   = IW'(cnt_q - 1'b1);
							rd_addr = ptr_add(head_q, IW'(cnt_q - 1'b1));
							state_d = S_SCAN;
						end
						res_d.now_empty = (cnt_d == '0);
					end else begin
						if (cnt_q == '0) begin
							res_d.status    = ST_EMPTY;
							res_d.now_empty = 1'b1;
						end else begin
							rd_addr = head_q;
							state_d = S_POP;
						end
					end
				end
			end
			S_SCAN: begin
				if (rd_data.prio > item_q.prio) begin
					wr_en   = 1'b1;
					wr_addr = pos_nx;
					wr_data = rd_data;
					if (idx_q == '0) begin
						state_d = S_PLACE;
					end else begin
						idx_d   = idx_q - 1'b1;
						rd_addr = pos_pv;
					end
				end else begin
					wr_en   = 1'b1;
					wr_addr = pos_nx;
					wr_data = held_entry;
					cnt_d   = cnt_q + 1'b1;
					state_d = S_DONE;
				end
			end
			S_PLACE: begin
				wr_en   = 1'b1;
				wr_addr = head_q;
				wr_data = held_entry;
				cnt_d   = cnt_q + 1'b1;
				state_d = S_DONE;
			end
			S_POP: begin
				res_d.status    = ST_OK;
				res_d.prio      = rd_data.prio;
				res_d.tag       = rd_data.tag;
				res_d.age       = rd_data.age;
				res_d.now_empty = (cnt_q == CW'(1));
				head_d          = ptr_inc(head_q);
				cnt_d           = cnt_q - 1'b1;
				state_d         = S_DONE;
			end
			S_DONE: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			cnt_q   <= '0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			cnt_q   <= cnt_d;
			idx_q   <= idx_d;
		end
	end

	always_ff @(posedge clk) begin
		if (load_item) begin
			item_q <= item;
		end
		res_q <= res_d;
	end

	assign res            = res_q;
	assign stat.idle      = (state_q == S_IDLE);
	assign stat.res_valid = (state_q == S_DONE);
	assign stat.count     = cnt_q;
endmodule
`default_nettype wire

@@ rtl/stable_priority_queue_unit.sv @@
// Top level of the stable priority queue: stream ports, output register, checks.
// Depends on spq_pkg, spq_engine and assert_macros.svh.
//
// channel   dir  tdata                                   tuser
// s_axis    in   prio[3:0] tag[35:4] age[43:36]          opcode
// m_axis    out  prio[3:0] tag[35:4] age[43:36] empty[44] status
//
// A pop reads the head entry in the pop state before its result is offered; a rejected
// item or an insert into an empty queue goes from idle straight to the done state.
// An insert into a nonempty queue scans down from the tail over the stored entries of
// worse priority; the entry RAM is walked one slot per cycle to shift them.
// Reset empties the queue at once; RAM contents are never read before written.
// A result waits in the output register while the next item is taken in.
`default_nettype none
module stable_priority_queue_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [47:0] s_axis_tdata,  // priority_req, record_tag, age, zero pad
	input  wire logic        s_axis_tuser,  // opcode
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [47:0] m_axis_tdata,  // out_priority, out_tag, out_age, now_empty, zero pad
	output logic      [1:0]  m_axis_tuser   // status
);
	import spq_pkg::*;

	`include "assert_macros.svh"

	item_t     item;
	result_t   res;
	eng_stat_t stat;
	logic      start;
	logic      res_ready;
	logic      m_valid_q;
	result_t   m_res_q;

	assign item.opcode = s_axis_tuser;
	assign item.prio   = s_axis_tdata[3:0];
	assign item.tag    = s_axis_tdata[35:4];
	assign item.age    = s_axis_tdata[43:36];

	assign s_axis_tready = stat.idle;
	assign start         = s_axis_tvalid && s_axis_tready;
	assign res_ready     = !m_valid_q || m_axis_tready;

	spq_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.item     (item),
		.res_ready(res_ready),
		.res      (res),
		.stat     (stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_ready) begin
			m_valid_q <= stat.res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && stat.res_valid) begin
			m_res_q <= res;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = m_res_q.status;
	assign m_axis_tdata  = {3'b000, m_res_q.now_empty, m_res_q.age, m_res_q.tag, m_res_q.prio};

	`SPQ_ASSERT(a_count_bound, stat.count <= DEPTH_C)
	`SPQ_ASSERT(a_busy_after_transfer, start |=> !s_axis_tready)
	`SPQ_ASSERT(a_count_step, !$stable(stat.count) |-> (stat.count == $past(stat.count) + 1'b1) || (stat.count + 1'b1 == $past(stat.count)))
	`SPQ_ASSERT(a_full_not_empty, m_axis_tvalid && m_axis_tuser == ST_FULL |-> !m_axis_tdata[44])
endmodule
`default_nettype wire
